FILE: rtl/core/pct_pkg.sv
package pct_pkg;

  // Sample width of every pixel field and of the range registers.
  localparam int unsigned SAMPLE_W = 16;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // Input and result words.
  typedef struct packed {
    sample_t red;
    sample_t green;
    sample_t blue;
  } pixel_in_t;

  typedef struct packed {
    sample_t out_red;
    sample_t out_green;
    sample_t out_blue;
  } pixel_out_t;

  // Transform modes; codes five to seven give an all-zero result.
  typedef enum logic [2:0] {
    MODE_BITMAP  = 3'd0,
    MODE_GRAY    = 3'd1,
    MODE_ISOLATE = 3'd2,
    MODE_REMOVE  = 3'd3,
    MODE_SEPIA   = 3'd4
  } mode_e;

  // Channel select codes; the spare code selects blue.
  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } channel_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_MODE     = 2'd0,
    REG_CHANNEL  = 2'd1,
    REG_IN_MAX   = 2'd2,
    REG_GRAY_MAX = 2'd3
  } reg_index_e;

  // Reset values of the range registers.
  localparam sample_t IN_MAX_RST   = 16'd255;
  localparam sample_t GRAY_MAX_RST = 16'd255;

  // Sepia matrix in thousandths, one row per result channel.
  localparam int unsigned COEF_W = 10;
  typedef logic [COEF_W-1:0] coef_t;
  localparam coef_t SEPIA_COEF [3][3] = '{
    '{10'd393, 10'd769, 10'd189},
    '{10'd349, 10'd686, 10'd168},
    '{10'd272, 10'd534, 10'd131}
  };

  // Widths along the sepia path.
  localparam int unsigned SUM_W   = SAMPLE_W + 2;
  localparam int unsigned TERM_W  = SAMPLE_W + COEF_W;
  localparam int unsigned ACC_W   = TERM_W + 1;

  // Division by three: floor(s * 349526 / 2^20) is exact for s below 2^18.
  localparam int unsigned DIV3_MUL_W = 19;
  localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 19'd349526;
  localparam int unsigned DIV3_SHIFT = 20;
  localparam int unsigned DIV3_PROD_W = SUM_W + DIV3_MUL_W;

  // Division by 1000: floor(a * 68719477 / 2^36) is exact for a below 2^27.
  localparam int unsigned DIV1000_MUL_W = 27;
  localparam logic [DIV1000_MUL_W-1:0] DIV1000_MUL = 27'd68719477;
  localparam int unsigned DIV1000_SHIFT = 36;
  localparam int unsigned DIV1000_PROD_W = ACC_W + DIV1000_MUL_W;
  localparam int unsigned SEPIA_Q_W = DIV1000_PROD_W - DIV1000_SHIFT;

  // Gray divider: one quotient bit per step, two steps per stage.
  localparam int unsigned GRAY_PROD_W   = 2 * SAMPLE_W;
  localparam int unsigned DIV_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES    = SAMPLE_W / DIV_PER_STAGE;

  // Partial remainder and the numerator bits still to shift in, which are
  // replaced by quotient bits from the bottom up.
  typedef struct packed {
    sample_t rem;
    sample_t nq;
  } div_state_t;

endpackage

FILE: rtl/core/pixel_color_transform_unit.sv
// Per-pixel colour transform: bitmap, gray, isolate channel, remove channel
// or sepia, as chosen by the mode register.
//
// Channels: pixel words enter on in_valid_i / in_ready_o / in_data_i and
// results leave on out_valid_o / out_ready_i / out_data_o, one result word
// for every pixel word. Registers are written on cfg_valid_i / cfg_ready_o
// with cfg_index_i and cfg_data_i; cfg_ready_o is always high. The user must
// write the registers only while no pixel is in flight; no check enforces it.
//
// Throughput is one word per cycle while out_ready_i lets the pipeline
// move. An accepted pixel word passes 13 register stages on its way out:
// four stages of multiply and add (sample products, reciprocal multiplies
// for the divisions by three and by 1000, gray product, sepia saturation),
// eight stages of the gray restoring divider at two quotient bits each,
// and the output register.
//
// Reset clears every valid bit and loads mode 0, channel 0 and both maximum
// values with 255. When the receiver holds out_ready_i low with a word
// waiting, the whole pipeline holds and in_ready_o drops; nothing is lost
// or repeated, and words behind a bubble keep their places.
module pixel_color_transform_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pct_pkg::pixel_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pct_pkg::pixel_out_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  pct_pkg::sample_t     cfg_data_i
);

  // One restoring division step.
  function automatic pct_pkg::div_state_t div_step(pct_pkg::div_state_t s,
                                                   pct_pkg::sample_t d);
    logic [pct_pkg::SAMPLE_W:0] trial;
    pct_pkg::div_state_t        r;
    trial = {s.rem, s.nq[pct_pkg::SAMPLE_W-1]};
    r.nq  = {s.nq[pct_pkg::SAMPLE_W-2:0], 1'b0};
    if (trial >= {1'b0, d}) begin
      r.rem   = pct_pkg::SAMPLE_W'(trial - {1'b0, d});
      r.nq[0] = 1'b1;
    end else begin
      r.rem = trial[pct_pkg::SAMPLE_W-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [2:0]       mode_q;
  logic [1:0]       channel_q;
  pct_pkg::sample_t in_max_q;
  pct_pkg::sample_t gray_max_q;
  pct_pkg::sample_t divisor;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= pct_pkg::MODE_BITMAP;
      channel_q  <= pct_pkg::CH_RED;
      in_max_q   <= pct_pkg::IN_MAX_RST;
      gray_max_q <= pct_pkg::GRAY_MAX_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pct_pkg::REG_MODE:     mode_q     <= cfg_data_i[2:0];
        pct_pkg::REG_CHANNEL:  channel_q  <= cfg_data_i[1:0];
        pct_pkg::REG_IN_MAX:   in_max_q   <= cfg_data_i;
        pct_pkg::REG_GRAY_MAX: gray_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A zero input maximum divides by one.
  assign divisor = (in_max_q == '0) ? pct_pkg::SAMPLE_W'(1) : in_max_q;

  // Global advance: the pipeline moves whenever the output word can move.
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // ---------------------------------------------------------------------
  // Stage A: channel sum and sepia products.
  pct_pkg::sample_t in_px [3];
  assign in_px[0] = in_data_i.red;
  assign in_px[1] = in_data_i.green;
  assign in_px[2] = in_data_i.blue;

  logic                           a_valid_q;
  pct_pkg::sample_t               a_px_q  [3];
  logic [pct_pkg::SUM_W-1:0]      a_sum_q;
  logic [pct_pkg::TERM_W-1:0]     a_term_q [3][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_sum_q <= pct_pkg::SUM_W'(in_px[0]) + pct_pkg::SUM_W'(in_px[1])
               + pct_pkg::SUM_W'(in_px[2]);
      for (int r = 0; r < 3; r++) begin
        a_px_q[r] <= in_px[r];
        for (int c = 0; c < 3; c++) begin
          a_term_q[r][c] <= pct_pkg::TERM_W'(pct_pkg::SEPIA_COEF[r][c])
                          * pct_pkg::TERM_W'(in_px[c]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: simple modes, sepia row sums and the reciprocal of three.
  logic                              b_valid_q;
  pct_pkg::pixel_out_t               b_res_q;
  pct_pkg::pixel_out_t               b_res_d;
  logic [pct_pkg::DIV3_PROD_W-1:0]   b_q3p_q;
  logic [pct_pkg::ACC_W-1:0]         b_acc_q [3];
  pct_pkg::sample_t                  half_max;
  logic [pct_pkg::SUM_W-1:0]         bit_thresh;
  pct_pkg::channel_e                 sel;

  assign half_max   = in_max_q >> 1;
  assign bit_thresh = (pct_pkg::SUM_W'(half_max) << 1) + pct_pkg::SUM_W'(half_max);

  always_comb begin
    case (channel_q)
      pct_pkg::CH_RED:   sel = pct_pkg::CH_RED;
      pct_pkg::CH_GREEN: sel = pct_pkg::CH_GREEN;
      default:           sel = pct_pkg::CH_BLUE;
    endcase
  end

  always_comb begin
    b_res_d = '0;
    case (mode_q)
      pct_pkg::MODE_BITMAP: begin
        b_res_d.out_red = (a_sum_q > bit_thresh) ? '0 : pct_pkg::SAMPLE_W'(1);
      end
      pct_pkg::MODE_ISOLATE: begin
        b_res_d.out_red   = (sel == pct_pkg::CH_RED)   ? a_px_q[0] : '0;
        b_res_d.out_green = (sel == pct_pkg::CH_GREEN) ? a_px_q[1] : '0;
        b_res_d.out_blue  = (sel == pct_pkg::CH_BLUE)  ? a_px_q[2] : '0;
      end
      pct_pkg::MODE_REMOVE: begin
        b_res_d.out_red   = (sel == pct_pkg::CH_RED)   ? '0 : a_px_q[0];
        b_res_d.out_green = (sel == pct_pkg::CH_GREEN) ? '0 : a_px_q[1];
        b_res_d.out_blue  = (sel == pct_pkg::CH_BLUE)  ? '0 : a_px_q[2];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_res_q <= b_res_d;
      b_q3p_q <= pct_pkg::DIV3_PROD_W'(a_sum_q) * pct_pkg::DIV3_PROD_W'(pct_pkg::DIV3_MUL);
      for (int r = 0; r < 3; r++) begin
        b_acc_q[r] <= pct_pkg::ACC_W'(a_term_q[r][0]) + pct_pkg::ACC_W'(a_term_q[r][1])
                    + pct_pkg::ACC_W'(a_term_q[r][2]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage C: gray product and the reciprocal of 1000.
  logic                                c_valid_q;
  pct_pkg::pixel_out_t                 c_res_q;
  logic [pct_pkg::GRAY_PROD_W-1:0]     c_gprod_q;
  logic [pct_pkg::DIV1000_PROD_W-1:0]  c_sprod_q [3];
  pct_pkg::sample_t                    third;

  assign third = b_q3p_q[pct_pkg::DIV3_SHIFT +: pct_pkg::SAMPLE_W];

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_res_q   <= b_res_q;
      c_gprod_q <= pct_pkg::GRAY_PROD_W'(third) * pct_pkg::GRAY_PROD_W'(gray_max_q);
      for (int r = 0; r < 3; r++) begin
        c_sprod_q[r] <= pct_pkg::DIV1000_PROD_W'(b_acc_q[r])
                      * pct_pkg::DIV1000_PROD_W'(pct_pkg::DIV1000_MUL);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage D: sepia saturation and divider set-up. A quotient of 2^16 or
  // more shows as the upper half reaching the divisor; it saturates.
  logic                   d_valid_q;
  pct_pkg::pixel_out_t    d_res_q;
  pct_pkg::pixel_out_t    d_res_d;
  pct_pkg::div_state_t    d_div_q;
  logic                   d_sat_q;
  pct_pkg::sample_t       sepia_px [3];
  logic [pct_pkg::SEPIA_Q_W-1:0] sepia_q [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sepia_q[r]  = c_sprod_q[r][pct_pkg::DIV1000_SHIFT +: pct_pkg::SEPIA_Q_W];
      sepia_px[r] = (sepia_q[r] > pct_pkg::SEPIA_Q_W'(in_max_q)) ?
                    in_max_q : sepia_q[r][pct_pkg::SAMPLE_W-1:0];
    end
    if (mode_q == pct_pkg::MODE_SEPIA) begin
      d_res_d.out_red   = sepia_px[0];
      d_res_d.out_green = sepia_px[1];
      d_res_d.out_blue  = sepia_px[2];
    end else begin
      d_res_d = c_res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_res_q     <= d_res_d;
      d_div_q.rem <= c_gprod_q[pct_pkg::GRAY_PROD_W-1:pct_pkg::SAMPLE_W];
      d_div_q.nq  <= c_gprod_q[pct_pkg::SAMPLE_W-1:0];
      d_sat_q     <= (c_gprod_q[pct_pkg::GRAY_PROD_W-1:pct_pkg::SAMPLE_W] >= divisor);
    end
  end

  // ---------------------------------------------------------------------
  // Gray divider stages, two quotient bits each.
  logic                 dv_valid_q [pct_pkg::DIV_STAGES];
  pct_pkg::pixel_out_t  dv_res_q   [pct_pkg::DIV_STAGES];
  pct_pkg::div_state_t  dv_div_q   [pct_pkg::DIV_STAGES];
  logic                 dv_sat_q   [pct_pkg::DIV_STAGES];
  pct_pkg::pixel_out_t  dv_res_in  [pct_pkg::DIV_STAGES];
  pct_pkg::div_state_t  dv_div_in  [pct_pkg::DIV_STAGES];
  logic                 dv_sat_in  [pct_pkg::DIV_STAGES];
  pct_pkg::div_state_t  dv_div_d   [pct_pkg::DIV_STAGES];

  always_comb begin
    dv_res_in[0] = d_res_q;
    dv_div_in[0] = d_div_q;
    dv_sat_in[0] = d_sat_q;
    for (int k = 1; k < pct_pkg::DIV_STAGES; k++) begin
      dv_res_in[k] = dv_res_q[k-1];
      dv_div_in[k] = dv_div_q[k-1];
      dv_sat_in[k] = dv_sat_q[k-1];
    end
    for (int k = 0; k < pct_pkg::DIV_STAGES; k++) begin
      dv_div_d[k] = dv_div_in[k];
      for (int s = 0; s < pct_pkg::DIV_PER_STAGE; s++) begin
        dv_div_d[k] = div_step(dv_div_d[k], divisor);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < pct_pkg::DIV_STAGES; k++) begin
        dv_res_q[k] <= dv_res_in[k];
        dv_div_q[k] <= dv_div_d[k];
        dv_sat_q[k] <= dv_sat_in[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register: gray result with saturation at the gray maximum.
  pct_pkg::pixel_out_t  out_data_q;
  pct_pkg::pixel_out_t  out_data_d;
  pct_pkg::div_state_t  last_div;

  assign last_div = dv_div_q[pct_pkg::DIV_STAGES-1];

  always_comb begin
    out_data_d = dv_res_q[pct_pkg::DIV_STAGES-1];
    if (mode_q == pct_pkg::MODE_GRAY) begin
      out_data_d.out_red   = (dv_sat_q[pct_pkg::DIV_STAGES-1] || last_div.nq > gray_max_q) ?
                             gray_max_q : last_div.nq;
      out_data_d.out_green = '0;
      out_data_d.out_blue  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
    end
  end

  // Valid bits travel with the words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < pct_pkg::DIV_STAGES; k++) begin
        dv_valid_q[k] <= 1'b0;
      end
    end else if (en) begin
      a_valid_q     <= in_valid_i;
      b_valid_q     <= a_valid_q;
      c_valid_q     <= b_valid_q;
      d_valid_q     <= c_valid_q;
      dv_valid_q[0] <= d_valid_q;
      for (int k = 1; k < pct_pkg::DIV_STAGES; k++) begin
        dv_valid_q[k] <= dv_valid_q[k-1];
      end
      out_valid_q   <= dv_valid_q[pct_pkg::DIV_STAGES-1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
